FILE: rtl/assert_macros.svh
// Assertion macros shared by the RC4 keystream RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/rc4rk_pkg.sv
// Types and constants shared by the rekeying RC4 keystream block
package rc4rk_pkg;

  localparam int unsigned STATE_BYTES = 256;
  localparam int unsigned SBOX_AW     = 8;

  localparam logic [30:0] LEHMER_MOD   = 31'h7FFF_FFFF;
  localparam logic [15:0] LEHMER_MUL   = 16'd48271;
  localparam logic [30:0] LEHMER_RESET = 31'd1;

  localparam int unsigned BLOCK_W   = 9;
  localparam logic [8:0]  BLOCK_MAX = 9'd256;

  localparam int unsigned CFG_IDX_W      = 1;
  localparam logic [0:0]  REG_SEED       = 1'b0;
  localparam logic [0:0]  REG_BLOCK_SIZE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY_MUL,
    ST_KEY_RED,
    ST_INIT,
    ST_KSA_RD,
    ST_KSA_J,
    ST_KSA_WK,
    ST_KSA_WJ,
    ST_GEN_I,
    ST_GEN_J,
    ST_GEN_T,
    ST_GEN_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_REKEY_BEGIN,
    OP_KEY_MUL,
    OP_KEY_RED,
    OP_INIT,
    OP_KSA_RD,
    OP_KSA_J,
    OP_KSA_WK,
    OP_KSA_WJ,
    OP_GEN_I,
    OP_GEN_J,
    OP_GEN_T,
    OP_GEN_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic k_last;     // S-box sweep counter at its final entry
    logic kidx_last;  // key byte index at its final entry
  } sts_t;

endpackage

FILE: rtl/rc4rk_ram.sv
// Generic single-write, single-read RAM with registered read data
module rc4rk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rc4rk_dp.sv
// Datapath: Lehmer key generator, S-box and key RAMs, RC4 index arithmetic
`include "assert_macros.svh"

module rc4rk_dp #(
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rc4rk_pkg::cmd_t   cmd,
  output rc4rk_pkg::sts_t   sts,
  input  logic              seed_we,
  input  logic [31:0]       seed_val,
  output logic [7:0]        out_byte
);

  localparam int unsigned KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [KW-1:0] KIDX_LAST = KW'(KEY_BYTES - 1);

  logic [30:0] lehmer_r, lehmer_nxt;
  logic [46:0] prod_r, prod_nxt;
  logic [KW-1:0] kidx_r, kidx_nxt, kidx_inc;
  logic [7:0] k_r, k_nxt;
  logic [7:0] i_r, i_nxt;
  logic [7:0] j_r, j_nxt;
  logic [7:0] si_r, si_nxt;
  logic [7:0] sj_r, sj_nxt;
  logic [7:0] t_r, t_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;

  logic [31:0] red_sum;
  logic [30:0] red_val;
  logic [31:0] seed_sum;
  logic [30:0] seed_mod;
  logic [30:0] seed_fold;

  logic       s_we, s_re;
  logic [7:0] s_waddr, s_wdata, s_raddr, s_rdata;
  logic       k_we, k_re;
  logic [7:0] k_rdata;

  logic [7:0] i_inc, ksa_j, gen_j, t_sum;

  // x mod (2^31-1): fold the bits above 2^31 back in, one correction
  assign red_sum = 32'(prod_r[46:31]) + 32'(prod_r[30:0]);
  assign red_val = (red_sum >= 32'(rc4rk_pkg::LEHMER_MOD)) ?
                   31'(red_sum - 32'(rc4rk_pkg::LEHMER_MOD)) : red_sum[30:0];

  assign seed_sum  = 32'(seed_val[31]) + 32'(seed_val[30:0]);
  assign seed_mod  = (seed_sum >= 32'(rc4rk_pkg::LEHMER_MOD)) ?
                     31'(seed_sum - 32'(rc4rk_pkg::LEHMER_MOD)) : seed_sum[30:0];
  assign seed_fold = (seed_mod == 31'd0) ? 31'd1 : seed_mod;

  assign kidx_inc = (kidx_r == KIDX_LAST) ? '0 : KW'(kidx_r + KW'(1));
  assign i_inc    = i_r + 8'd1;
  assign ksa_j    = j_r + s_rdata + k_rdata;
  assign gen_j    = j_r + s_rdata;
  assign t_sum    = si_r + s_rdata;

  assign sts.k_last    = (k_r == 8'hFF);
  assign sts.kidx_last = (kidx_r == KIDX_LAST);

  always_comb begin
    lehmer_nxt   = lehmer_r;
    prod_nxt     = prod_r;
    kidx_nxt     = kidx_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    si_nxt       = si_r;
    sj_nxt       = sj_r;
    t_nxt        = t_r;
    out_byte_nxt = out_byte_r;
    s_we         = 1'b0;
    s_waddr      = k_r;
    s_wdata      = k_r;
    s_re         = 1'b0;
    s_raddr      = k_r;
    k_we         = 1'b0;
    k_re         = 1'b0;
    unique case (cmd.op)
      rc4rk_pkg::OP_NONE: begin
      end
      rc4rk_pkg::OP_REKEY_BEGIN: begin
        kidx_nxt = '0;
        k_nxt    = 8'd0;
        i_nxt    = 8'd0;
        j_nxt    = 8'd0;
      end
      rc4rk_pkg::OP_KEY_MUL: begin
        prod_nxt = 47'(lehmer_r) * 47'(rc4rk_pkg::LEHMER_MUL);
      end
      rc4rk_pkg::OP_KEY_RED: begin
        lehmer_nxt = red_val;
        k_we       = 1'b1;
        kidx_nxt   = kidx_inc;
      end
      rc4rk_pkg::OP_INIT: begin
        s_we  = 1'b1;
        k_nxt = k_r + 8'd1;
      end
      rc4rk_pkg::OP_KSA_RD: begin
        s_re = 1'b1;
        k_re = 1'b1;
      end
      rc4rk_pkg::OP_KSA_J: begin
        s_re    = 1'b1;
        s_raddr = ksa_j;
        j_nxt   = ksa_j;
        si_nxt  = s_rdata;
      end
      rc4rk_pkg::OP_KSA_WK: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
      end
      rc4rk_pkg::OP_KSA_WJ: begin
        s_we     = 1'b1;
        s_waddr  = j_r;
        s_wdata  = si_r;
        k_nxt    = k_r + 8'd1;
        kidx_nxt = kidx_inc;
        // schedule done: output phase restarts with j at zero
        if (sts.k_last) begin
          j_nxt = 8'd0;
        end
      end
      rc4rk_pkg::OP_GEN_I: begin
        s_re    = 1'b1;
        s_raddr = i_inc;
        i_nxt   = i_inc;
      end
      rc4rk_pkg::OP_GEN_J: begin
        s_re    = 1'b1;
        s_raddr = gen_j;
        j_nxt   = gen_j;
        si_nxt  = s_rdata;
      end
      rc4rk_pkg::OP_GEN_T: begin
        s_we    = 1'b1;
        s_waddr = i_r;
        s_wdata = s_rdata;
        s_re    = 1'b1;
        s_raddr = t_sum;
        sj_nxt  = s_rdata;
        t_nxt   = t_sum;
      end
      rc4rk_pkg::OP_GEN_OUT: begin
        s_we    = 1'b1;
        s_waddr = j_r;
        s_wdata = si_r;
        // read of S[t] predates the swap; bypass the two swapped entries
        if (t_r == j_r) begin
          out_byte_nxt = si_r;
        end else if (t_r == i_r) begin
          out_byte_nxt = sj_r;
        end else begin
          out_byte_nxt = s_rdata;
        end
      end
      default: begin
      end
    endcase
    if (seed_we) begin
      lehmer_nxt = seed_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lehmer_r <= rc4rk_pkg::LEHMER_RESET;
      kidx_r   <= '0;
      k_r      <= 8'd0;
      i_r      <= 8'd0;
      j_r      <= 8'd0;
    end else begin
      lehmer_r <= lehmer_nxt;
      kidx_r   <= kidx_nxt;
      k_r      <= k_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_byte = out_byte_r;

  rc4rk_ram #(
    .WIDTH (8),
    .DEPTH (rc4rk_pkg::STATE_BYTES)
  ) u_sbox (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  rc4rk_ram #(
    .WIDTH (8),
    .DEPTH (KEY_BYTES)
  ) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (kidx_r),
    .wdata (red_val[7:0]),
    .re    (k_re),
    .raddr (kidx_r),
    .rdata (k_rdata)
  );

  `ASSERT_CLK(a_ksa_end, (cmd.op == rc4rk_pkg::OP_KSA_WJ) && sts.k_last |=> (k_r == 8'd0) && (j_r == 8'd0), "schedule did not end with k and j at zero")
  `ASSERT_NEVER(a_lehmer_zero, lehmer_r == 31'd0, "Lehmer state reached zero")

endmodule

FILE: rtl/rc4rk_ctrl.sv
// Controller: sequencing of rekey and byte generation, block position, output valid
`include "assert_macros.svh"

module rc4rk_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_last,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [rc4rk_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rc4rk_pkg::BLOCK_W-1:0]   cfg_bsize,
  input  rc4rk_pkg::sts_t                sts,
  output rc4rk_pkg::cmd_t                cmd
);

  rc4rk_pkg::state_t state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rc4rk_pkg::BLOCK_W-1:0] pos_r, pos_nxt;
  logic [rc4rk_pkg::BLOCK_W-1:0] bsize_r, bsize_nxt;
  logic [rc4rk_pkg::BLOCK_W-1:0] eff_size, pos_inc;
  logic                          in_acc;

  assign in_tready = (state_r == rc4rk_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign pos_inc   = pos_r + 9'd1;

  always_comb begin
    priority if (bsize_r == 9'd0) begin
      eff_size = 9'd1;
    end else if (bsize_r > rc4rk_pkg::BLOCK_MAX) begin
      eff_size = rc4rk_pkg::BLOCK_MAX;
    end else begin
      eff_size = bsize_r;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      pos_nxt = (in_last || (pos_inc >= eff_size)) ? 9'd0 : pos_inc;
    end
    bsize_nxt = bsize_r;
    if (cfg_we && (cfg_idx == rc4rk_pkg::REG_BLOCK_SIZE)) begin
      bsize_nxt = cfg_bsize;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rc4rk_pkg::OP_NONE;
    unique case (state_r)
      rc4rk_pkg::ST_IDLE: begin
        if (in_acc) begin
          // block start: fresh key before the byte
          if (pos_r == 9'd0) begin
            cmd.op    = rc4rk_pkg::OP_REKEY_BEGIN;
            state_nxt = rc4rk_pkg::ST_KEY_MUL;
          end else begin
            cmd.op    = rc4rk_pkg::OP_GEN_I;
            state_nxt = rc4rk_pkg::ST_GEN_J;
          end
        end
      end
      rc4rk_pkg::ST_KEY_MUL: begin
        cmd.op    = rc4rk_pkg::OP_KEY_MUL;
        state_nxt = rc4rk_pkg::ST_KEY_RED;
      end
      rc4rk_pkg::ST_KEY_RED: begin
        cmd.op    = rc4rk_pkg::OP_KEY_RED;
        state_nxt = sts.kidx_last ? rc4rk_pkg::ST_INIT : rc4rk_pkg::ST_KEY_MUL;
      end
      rc4rk_pkg::ST_INIT: begin
        cmd.op = rc4rk_pkg::OP_INIT;
        if (sts.k_last) begin
          state_nxt = rc4rk_pkg::ST_KSA_RD;
        end
      end
      rc4rk_pkg::ST_KSA_RD: begin
        cmd.op    = rc4rk_pkg::OP_KSA_RD;
        state_nxt = rc4rk_pkg::ST_KSA_J;
      end
      rc4rk_pkg::ST_KSA_J: begin
        cmd.op    = rc4rk_pkg::OP_KSA_J;
        state_nxt = rc4rk_pkg::ST_KSA_WK;
      end
      rc4rk_pkg::ST_KSA_WK: begin
        cmd.op    = rc4rk_pkg::OP_KSA_WK;
        state_nxt = rc4rk_pkg::ST_KSA_WJ;
      end
      rc4rk_pkg::ST_KSA_WJ: begin
        cmd.op    = rc4rk_pkg::OP_KSA_WJ;
        state_nxt = sts.k_last ? rc4rk_pkg::ST_GEN_I : rc4rk_pkg::ST_KSA_RD;
      end
      rc4rk_pkg::ST_GEN_I: begin
        cmd.op    = rc4rk_pkg::OP_GEN_I;
        state_nxt = rc4rk_pkg::ST_GEN_J;
      end
      rc4rk_pkg::ST_GEN_J: begin
        cmd.op    = rc4rk_pkg::OP_GEN_J;
        state_nxt = rc4rk_pkg::ST_GEN_T;
      end
      rc4rk_pkg::ST_GEN_T: begin
        cmd.op    = rc4rk_pkg::OP_GEN_T;
        state_nxt = rc4rk_pkg::ST_GEN_OUT;
      end
      rc4rk_pkg::ST_GEN_OUT: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          cmd.op    = rc4rk_pkg::OP_GEN_OUT;
          state_nxt = rc4rk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rc4rk_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.op == rc4rk_pkg::OP_GEN_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4rk_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= 9'd0;
      bsize_r     <= rc4rk_pkg::BLOCK_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      bsize_r     <= bsize_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `ASSERT_CLK(a_rekey_on_start, in_acc && (pos_r == 9'd0) |=> state_r == rc4rk_pkg::ST_KEY_MUL, "block start did not rekey")
  `ASSERT_CLK(a_out_after_gen, (state_r == rc4rk_pkg::ST_GEN_OUT) && (state_nxt == rc4rk_pkg::ST_IDLE) |=> out_valid_r, "finished byte not presented")
  `ASSERT_NEVER(a_pos_range, pos_r > 9'd255, "block position out of range")

endmodule

FILE: rtl/rc4_rekeyed_block_keystream.sv
// Top level of the rekeying RC4 keystream block
// Each accepted request returns one RC4 keystream byte. Within a block the byte
// reaches the result register through these steps: S-box read at i on the
// transfer edge, read at j, swap write plus read at S[i]+S[j], second swap
// write, all through the single read and single write port of the 256-byte
// S-box RAM, so a request is taken only once the previous byte is through them.
// At a block start the request first rekeys: Lehmer steps (a multiply and a
// reduction per key byte), fill of all 256 S-box entries, the key schedule and
// one more step for the read at i, which then no longer shares the transfer
// cycle. A finished byte holds until the output register is free. The next
// request is taken while the byte waits on the output register. After reset
// the first request rekeys from seed 1.
module rc4_rekeyed_block_keystream #(
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] last_of_read
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] stream_byte
  input  logic                            cfg_we,
  input  logic [rc4rk_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                     cfg_wdata
);

  rc4rk_pkg::cmd_t cmd;
  rc4rk_pkg::sts_t sts;
  logic            seed_we;

  assign seed_we = cfg_we && (cfg_idx == rc4rk_pkg::REG_SEED);

  rc4rk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_last    (in_tdata[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_bsize  (cfg_wdata[rc4rk_pkg::BLOCK_W-1:0]),
    .sts        (sts),
    .cmd        (cmd)
  );

  rc4rk_dp #(
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .seed_we  (seed_we),
    .seed_val (cfg_wdata),
    .out_byte (out_tdata)
  );

endmodule

FILE: test/rc4rk_keystream_checker.sv
// Checker for the rekeying RC4 keystream block: watches the channels and predicts each byte
`timescale 1ns / 100ps

module rc4rk_keystream_checker
  import rc4rk_pkg::*;
#(
  parameter int unsigned KEY_LEN = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] last_of_read
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,  // [7:0] stream_byte
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata,
  output int                   errors,
  output int                   pending,
  output int                   checked,
  output int                   rekeys
);

  logic [7:0]  sbox [STATE_BYTES];
  logic [7:0]  idx_i;
  logic [7:0]  idx_j;
  logic [30:0] lehmer_x;
  logic [8:0]  blk_size;
  logic [8:0]  blk_pos;
  logic [7:0]  keystream_q [$];

  function automatic logic [30:0] minstd_next(input logic [30:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(LEHMER_MUL);
    return 31'(p % 64'(LEHMER_MOD));
  endfunction

  function automatic logic [8:0] block_limit(input logic [8:0] sz);
    if (sz == '0) return 9'd1;
    if (sz > BLOCK_MAX) return BLOCK_MAX;
    return sz;
  endfunction

  task automatic reload_generator(input logic [31:0] s);
    logic [31:0] v;
    v = s % {1'b0, LEHMER_MOD};
    lehmer_x = (v == '0) ? LEHMER_RESET : v[30:0];
  endtask

  // fresh key from the Lehmer generator, then the usual key schedule
  task automatic rekey_sbox();
    logic [7:0] key [KEY_LEN];
    logic [7:0] jj;
    logic [7:0] t;
    int k;
    for (k = 0; k < KEY_LEN; k++) begin
      lehmer_x = minstd_next(lehmer_x);
      key[k] = lehmer_x[7:0];
    end
    for (k = 0; k < STATE_BYTES; k++) sbox[k] = 8'(k);
    jj = '0;
    for (k = 0; k < STATE_BYTES; k++) begin
      jj = jj + sbox[k] + key[k % KEY_LEN];
      t = sbox[k];
      sbox[k] = sbox[jj];
      sbox[jj] = t;
    end
    idx_i = '0;
    idx_j = '0;
    rekeys++;
  endtask

  task automatic predict_keystream_byte(input logic last, output logic [7:0] b);
    logic [7:0] t;
    logic [7:0] sum;
    if (blk_pos == '0) rekey_sbox();
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    t = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = t;
    sum = sbox[idx_i] + sbox[idx_j];
    b = sbox[sum];
    blk_pos = blk_pos + 9'd1;
    if (last || blk_pos >= block_limit(blk_size)) blk_pos = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("checker: %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      idx_i = '0;
      idx_j = '0;
      blk_size = BLOCK_MAX;
      blk_pos = '0;
      reload_generator(32'd1);
      keystream_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SEED:       reload_generator(cfg_wdata);
          REG_BLOCK_SIZE: blk_size = cfg_wdata[8:0];
          default: ;
        endcase
      end
      // results first, so a byte on the same edge as a request cannot match it
      if (out_tvalid && out_tready) begin
        if (keystream_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h with none outstanding", out_tdata));
        end else begin
          want = keystream_q.pop_front();
          checked++;
          if (out_tdata[7:0] !== want)
            report_mismatch($sformatf("stream_byte %02h, predicted %02h", out_tdata, want));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_keystream_byte(in_tdata[0], want);
        keystream_q.push_back(want);
      end
    end
    pending <= keystream_q.size();
  end

endmodule

FILE: test/tb.sv
// Top of the keystream testbench: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb;
  import rc4rk_pkg::*;

  localparam int RANDOM_REQS = 1100;
  localparam int IDLE_LIMIT  = 10000;  // well above the length of a rekey

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_wdata;

  int         errors;
  int         pending;
  int         checked;
  int         rekeys;
  int         sent;
  int         cfg_writes;
  int         idle_cycles;
  bit         burst;
  logic [8:0] cur_blk;

  rc4_rekeyed_block_keystream dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  rc4rk_keystream_checker keystream_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .rekeys     (rekeys)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // result side: random stall before each transfer, none while bursting
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_req(input bit last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, last};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_registers(input bit wr_seed, input logic [31:0] seed_val,
                                 input bit wr_blk, input logic [31:0] blk_val);
    drain_results();
    if (wr_seed) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_SEED;
      cfg_wdata <= seed_val;
      @(posedge clk);
      cfg_writes++;
    end
    if (wr_blk) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_BLOCK_SIZE;
      cfg_wdata <= blk_val;
      @(posedge clk);
      cfg_writes++;
      cur_blk = blk_val[8:0];
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n_reqs;
    int r;
    bit wr_seed;
    bit wr_blk;
    logic [31:0] seed_val;
    logic [31:0] blk_val;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    burst     = 1'b0;
    cur_blk   = BLOCK_MAX;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: seed 1, full blocks; last_of_read forces a rekey
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);
    // shrink block mid-block
    write_registers(1'b0, '0, 1'b1, 32'd3);
    repeat (3) send_req(1'b0);
    // seed zero folds to one; size zero acts as one
    write_registers(1'b1, 32'd0, 1'b1, 32'd0);
    repeat (3) send_req(1'b0);
    // all-ones seed, oversize block saturates
    write_registers(1'b1, 32'hFFFF_FFFF, 1'b1, 32'd511);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);
    // seed equal to the modulus folds to one
    write_registers(1'b1, 32'h7FFF_FFFF, 1'b1, 32'd256);
    repeat (5) send_req(1'b0);
    // new size below the position already reached closes the block
    write_registers(1'b0, '0, 1'b1, 32'd2);
    repeat (2) send_req(1'b0);
    // upper write-data bits beyond the 9-bit field are dropped
    write_registers(1'b1, 32'h7FFF_FFFE, 1'b1, 32'hFFFF_FE01);
    repeat (2) send_req(1'b1);

    n_reqs = sent;
    while (sent < n_reqs + RANDOM_REQS) begin
      burst   = ($urandom_range(0, 3) == 0);
      wr_seed = $urandom_range(0, 1);
      wr_blk  = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 5))
        0:       seed_val = 32'd0;
        1:       seed_val = 32'h7FFF_FFFF;
        2:       seed_val = 32'hFFFF_FFFF;
        default: seed_val = $urandom;
      endcase
      r = $urandom_range(0, 9);
      if (r == 0)
        blk_val = $urandom_range(0, 3);
      else if (r == 1)
        blk_val = ($urandom & 32'hFFFF_FE00) | $urandom_range(257, 511);
      else
        blk_val = $urandom_range(4, 256);
      if (wr_seed || wr_blk) write_registers(wr_seed, seed_val, wr_blk, blk_val);
      // tiny blocks rekey on nearly every byte, so keep those phases short
      if (cur_blk <= 9'd3)
        r = $urandom_range(2, 5);
      else
        r = $urandom_range(10, 60);
      repeat (r) send_req($urandom_range(0, 11) == 0);
    end

    burst = 1'b0;
    drain_results();
    repeat (16) @(posedge clk);
    $display("tb: %0d requests sent, %0d keystream bytes checked, %0d rekeys predicted",
             sent, checked, rekeys);
    $display("tb: %0d register writes, %0d mismatches", cfg_writes, errors);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/rc4rk_pkg.sv
rtl/rc4rk_ram.sv
rtl/rc4rk_dp.sv
rtl/rc4rk_ctrl.sv
rtl/rc4_rekeyed_block_keystream.sv
test/rc4rk_keystream_checker.sv
test/tb.sv
